@@ hdl/least_work_queue_dispatcher_macros.svh @@
// assertion macros shared by the least-work queue dispatcher modules
`ifndef LEAST_WORK_QUEUE_DISPATCHER_MACROS_SVH
`define LEAST_WORK_QUEUE_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define LWQD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lwqd assertion failed");

// condition must never be true outside reset
`define LWQD_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lwqd forbidden condition seen");

`else

`define LWQD_ASSERT(label, clk, rst, prop)
`define LWQD_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

@@ hdl/lwqd_pkg.sv @@
// shared types and constants of the least-work queue dispatcher
package lwqd_pkg;

  // sizing (queue depth must be a power of two)
  localparam int NUM_SERVERS = 4;
  localparam int QUEUE_DEPTH = 16;

  // fixed field widths
  localparam int SRV_FIELD_W = 2;
  localparam int ID_W        = 16;
  localparam int LEN_W       = 8;
  localparam int LOAD_W      = 12;
  localparam int STATUS_W    = 2;
  localparam int ACTIVE_W    = 3;

  // derived widths
  localparam int SRV_W      = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SRV_CNT_W  = $clog2(NUM_SERVERS + 1);
  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_SERVERS * QUEUE_DEPTH;
  localparam int ADDR_W     = SRV_W + PTR_W;
  localparam int JOB_W      = ID_W + LEN_W;

  localparam logic [LOAD_W-1:0]   LOAD_MAX      = '1;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = ACTIVE_W'(NUM_SERVERS);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                   action;
    logic [ID_W-1:0]        job_id;
    logic [LEN_W-1:0]       job_length;
    logic [SRV_FIELD_W-1:0] server_index;
  } in_item_t;

  typedef struct packed {
    logic [SRV_FIELD_W-1:0] chosen_server;
    logic [ID_W-1:0]        out_job_id;
    logic [LEN_W-1:0]       out_job_length;
    logic [STATUS_W-1:0]    status;
    logic [LOAD_W-1:0]      server_load;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                   is_take;
    logic [ID_W-1:0]        job_id;
    logic [LEN_W-1:0]       job_length;
    logic [SRV_FIELD_W-1:0] server_index;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_TAKE
  } back_state_t;

endpackage

@@ hdl/lwqd_ram.sv @@
// generic single-write, single-read ram with registered read data
module lwqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lwqd_front.sv @@
// front end: accepts input transactions, classifies them and queues commands
`include "least_work_queue_dispatcher_macros.svh"

module lwqd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lwqd_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output lwqd_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);
  import lwqd_pkg::*;

  cmd_t                  q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] q_cnt;
  logic                  push;
  logic                  pop;
  cmd_t                  cls;

  // classify the incoming item
  always_comb begin
    cls.job_id       = in_data.job_id;
    cls.job_length   = in_data.job_length;
    cls.server_index = in_data.server_index;
    unique case (in_data.action)
      ACT_ADD:  cls.is_take = 1'b0;
      ACT_TAKE: cls.is_take = 1'b1;
      default:  cls.is_take = 1'b0;
    endcase
  end

  assign in_ready  = (q_cnt != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (q_cnt != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  // command queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // command queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_cnt <= q_cnt + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end
  end

  // an accepted transaction always leaves something queued
  `LWQD_ASSERT(a_push_fills, clk, rst, push |=> (q_cnt != '0))
  // the back end only pops a queued command
  `LWQD_ASSERT_NEVER(a_pop_empty, clk, rst, cmd_pop && (q_cnt == '0))

endmodule

@@ hdl/lwqd_back.sv @@
// back end: per-server fifo bookkeeping, least-load selection and result register
`include "least_work_queue_dispatcher_macros.svh"

module lwqd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [lwqd_pkg::ACTIVE_W-1:0]  cfg_data,
  input  logic                           cmd_valid,
  input  lwqd_pkg::cmd_t                 cmd,
  output logic                           cmd_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lwqd_pkg::out_item_t            out_data
);
  import lwqd_pkg::*;

  back_state_t       state, state_next;
  logic [PTR_W-1:0]  head [NUM_SERVERS];
  logic [PTR_W-1:0]  head_next [NUM_SERVERS];
  logic [CNT_W-1:0]  cnt [NUM_SERVERS];
  logic [CNT_W-1:0]  cnt_next [NUM_SERVERS];
  logic [LOAD_W-1:0] load [NUM_SERVERS];
  logic [LOAD_W-1:0] load_next [NUM_SERVERS];
  logic [ACTIVE_W-1:0] active;
  logic [SRV_W-1:0]  tk_srv, tk_srv_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [JOB_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [JOB_W-1:0]  ram_rdata;

  logic [SRV_CNT_W-1:0] n_eff;
  logic [SRV_W-1:0]     best;
  logic [SRV_W-1:0]     ts;
  logic                 srv_ok;
  logic                 out_free;

  lwqd_ram #(
    .WIDTH (JOB_W),
    .DEPTH (STORE_DEPTH)
  ) u_job_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective number of dispatch servers
  always_comb begin
    if (active == '0) begin
      n_eff = SRV_CNT_W'(1);
    end else if (32'(active) > NUM_SERVERS) begin
      n_eff = SRV_CNT_W'(NUM_SERVERS);
    end else begin
      n_eff = SRV_CNT_W'(active);
    end
  end

  // least load among active servers, ties to lowest index
  always_comb begin
    best = '0;
    for (int i = 1; i < NUM_SERVERS; i++) begin
      if ((i < 32'(n_eff)) && (load[i] < load[best])) begin
        best = SRV_W'(i);
      end
    end
  end

  assign ts       = SRV_W'(cmd.server_index);
  assign srv_ok   = 32'(cmd.server_index) < NUM_SERVERS;
  assign out_free = !out_valid || out_ready;

  // next state, fifo updates and result formation
  always_comb begin
    logic [PTR_W-1:0]  slot;
    logic [LOAD_W:0]   sum;
    logic [LEN_W-1:0]  tlen;
    state_next     = state;
    head_next      = head;
    cnt_next       = cnt;
    load_next      = load;
    tk_srv_next    = tk_srv;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    slot           = '0;
    sum            = '0;
    tlen           = '0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (!cmd.is_take) begin
            out_valid_next               = 1'b1;
            out_data_next.chosen_server  = SRV_FIELD_W'(best);
            out_data_next.out_job_id     = cmd.job_id;
            out_data_next.out_job_length = cmd.job_length;
            if (cnt[best] == CNT_W'(QUEUE_DEPTH)) begin
              // queue full, job dropped
              out_data_next.status      = ST_FULL;
              out_data_next.server_load = load[best];
            end else begin
              slot      = head[best] + PTR_W'(cnt[best]);
              ram_we    = 1'b1;
              ram_waddr = {best, slot};
              ram_wdata = {cmd.job_id, cmd.job_length};
              cnt_next[best] = cnt[best] + 1'b1;
              sum = {1'b0, load[best]} + (LOAD_W + 1)'(cmd.job_length);
              load_next[best] = (sum > {1'b0, LOAD_MAX}) ? LOAD_MAX : sum[LOAD_W-1:0];
              out_data_next.status      = ST_DONE;
              out_data_next.server_load = load_next[best];
            end
          end else if (!srv_ok || (cnt[ts] == '0)) begin
            // take from an empty queue
            out_valid_next               = 1'b1;
            out_data_next.chosen_server  = cmd.server_index;
            out_data_next.out_job_id     = '0;
            out_data_next.out_job_length = '0;
            out_data_next.status         = ST_EMPTY;
            out_data_next.server_load    = srv_ok ? load[ts] : '0;
          end else begin
            // pop the front entry, finish when read data returns
            ram_re        = 1'b1;
            ram_raddr     = {ts, head[ts]};
            head_next[ts] = head[ts] + 1'b1;
            cnt_next[ts]  = cnt[ts] - 1'b1;
            tk_srv_next   = ts;
            state_next    = B_TAKE;
          end
        end
      end
      B_TAKE: begin
        if (out_free) begin
          tlen = ram_rdata[LEN_W-1:0];
          load_next[tk_srv] = (load[tk_srv] >= LOAD_W'(tlen)) ?
                              (load[tk_srv] - LOAD_W'(tlen)) : '0;
          out_valid_next               = 1'b1;
          out_data_next.chosen_server  = SRV_FIELD_W'(tk_srv);
          out_data_next.out_job_id     = ram_rdata[JOB_W-1:LEN_W];
          out_data_next.out_job_length = tlen;
          out_data_next.status         = ST_DONE;
          out_data_next.server_load    = load_next[tk_srv];
          state_next                   = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      active    <= ACTIVE_RESET;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
        load[i] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      head      <= head_next;
      cnt       <= cnt_next;
      load      <= load_next;
      if (cfg_valid) begin
        active <= cfg_data;
      end
    end
  end

  // result payload and pending take server
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    tk_srv   <= tk_srv_next;
  end

  // a full-queue result is only reported while that queue is still full
  `LWQD_ASSERT(a_full_result, clk, rst,
    (out_valid && (out_data.status == ST_FULL)) |->
    (cnt[SRV_W'(out_data.chosen_server)] == CNT_W'(QUEUE_DEPTH)))
  // a pending take keeps its server until it completes
  `LWQD_ASSERT(a_take_holds, clk, rst,
    (state == B_TAKE) |=> ((state == B_IDLE) || $stable(tk_srv)))
  // the job store is never written and read in one cycle
  `LWQD_ASSERT_NEVER(a_ram_one_port, clk, rst, ram_we && ram_re)

endmodule

@@ hdl/least_work_queue_dispatcher.sv @@
// top level of the least-work queue dispatcher
// Dispatches jobs to per-server fifos (16 entries each) by least queued work among
// the active servers, and pops front jobs on take requests; one result per input
// transaction. The front end queues up to two classified commands. In the back end
// an add completes in B_IDLE (load minimum over the four load registers plus one
// job store write); a take also needs B_TAKE, as job store read data is registered.
// A new command may follow an add without waiting, but none is taken while a take waits
// in B_TAKE or while back-pressure holds the output register. A result passes the
// command queue and, for a take, the job store read register, then out_data.
// The active_servers register is written over the cfg channel, which is always ready,
// and should only be written while the block is idle.
module least_work_queue_dispatcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lwqd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lwqd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lwqd_pkg::ACTIVE_W-1:0] cfg_data
);
  import lwqd_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // accept and classify
  lwqd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // execute against the server fifos
  lwqd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ dv/least_work_queue_dispatcher_tb.sv @@
// testbench for the least-work queue dispatcher: random and directed traffic, checked against a predictor
`timescale 1ns / 100ps

module least_work_queue_dispatcher_tb;
  import lwqd_pkg::*;

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned SEG_COUNT      = 6;
  localparam int unsigned SEG_ITEMS      = 265;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACTIVE_W-1:0] cfg_data = '0;

  // stimulus and scoreboard storage
  in_item_t  job_requests_q[$];
  out_item_t dispatch_outcomes_q[$];
  int        unsent_jobs = 0;
  logic      in_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count = 0;

  // predictor state
  logic [JOB_W-1:0]    job_slots [STORE_DEPTH];
  logic [PTR_W-1:0]    srv_head  [NUM_SERVERS];
  logic [CNT_W-1:0]    srv_count [NUM_SERVERS];
  logic [LOAD_W-1:0]   srv_load  [NUM_SERVERS];
  logic [ACTIVE_W-1:0] active_cfg = ACTIVE_RESET;

  // run statistics
  int unsigned added_jobs = 0;
  int unsigned dropped_adds = 0;
  int unsigned served_jobs = 0;
  int unsigned empty_takes = 0;
  int unsigned cfg_writes = 0;

  logic [ACTIVE_W-1:0] seg_active [SEG_COUNT];

  least_work_queue_dispatcher dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // number of servers that take part in least-work dispatch
  function automatic int unsigned effective_servers();
    if (active_cfg < 1) return 1;
    if (active_cfg > NUM_SERVERS) return NUM_SERVERS;
    return 32'(active_cfg);
  endfunction

  // advance the queue state by one transaction and return its result
  function automatic out_item_t dispatch_outcome(input in_item_t req);
    out_item_t           res;
    int unsigned         n, best, idx;
    logic [PTR_W-1:0]    slot;
    logic [LOAD_W:0]     sum;
    logic [JOB_W-1:0]    entry;
    res = '0;
    if (req.action == ACT_ADD) begin
      n = effective_servers();
      best = 0;
      for (idx = 1; idx < n; idx++)
        if (srv_load[idx] < srv_load[best]) best = idx;
      res.chosen_server  = SRV_FIELD_W'(best);
      res.out_job_id     = req.job_id;
      res.out_job_length = req.job_length;
      if (srv_count[best] >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        dropped_adds++;
      end else begin
        slot = PTR_W'(srv_head[best] + srv_count[best]);
        job_slots[best * QUEUE_DEPTH + slot] = {req.job_id, req.job_length};
        srv_count[best] = srv_count[best] + 1'b1;
        sum = {1'b0, srv_load[best]} + req.job_length;
        srv_load[best] = (sum > LOAD_MAX) ? LOAD_MAX : sum[LOAD_W-1:0];
        res.status = ST_DONE;
        added_jobs++;
      end
      res.server_load = srv_load[best];
    end else begin
      idx = 32'(req.server_index);
      res.chosen_server = req.server_index;
      if (idx >= NUM_SERVERS) begin
        res.status = ST_EMPTY;
        empty_takes++;
      end else if (srv_count[idx] == 0) begin
        res.status      = ST_EMPTY;
        res.server_load = srv_load[idx];
        empty_takes++;
      end else begin
        entry = job_slots[idx * QUEUE_DEPTH + srv_head[idx]];
        srv_head[idx]  = srv_head[idx] + 1'b1;
        srv_count[idx] = srv_count[idx] - 1'b1;
        srv_load[idx]  = (srv_load[idx] >= entry[LEN_W-1:0]) ?
                         srv_load[idx] - entry[LEN_W-1:0] : '0;
        res.out_job_id     = entry[JOB_W-1:LEN_W];
        res.out_job_length = entry[LEN_W-1:0];
        res.status         = ST_DONE;
        res.server_load    = srv_load[idx];
        served_jobs++;
      end
    end
    return res;
  endfunction

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("error at %0t: %s", $realtime, msg);
  endfunction

  // stimulus helpers
  function automatic logic [LEN_W-1:0] random_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return LEN_W'($urandom);
  endfunction

  function automatic in_item_t make_add(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len);
    in_item_t req;
    req.action       = ACT_ADD;
    req.job_id       = id;
    req.job_length   = len;
    req.server_index = SRV_FIELD_W'($urandom);
    return req;
  endfunction

  function automatic in_item_t make_take(input logic [SRV_FIELD_W-1:0] srv);
    in_item_t req;
    req.action       = ACT_TAKE;
    req.job_id       = ID_W'($urandom);
    req.job_length   = LEN_W'($urandom);
    req.server_index = srv;
    return req;
  endfunction

  function automatic void push_job(input in_item_t req);
    job_requests_q = {job_requests_q, req};
    unsent_jobs++;
  endfunction

  // mostly serve dispatching servers so queues drain, sometimes any server
  function automatic logic [SRV_FIELD_W-1:0] pick_take_server();
    if ($urandom_range(0, 99) < 75)
      return SRV_FIELD_W'($urandom_range(0, effective_servers() - 1));
    return SRV_FIELD_W'($urandom_range(0, NUM_SERVERS - 1));
  endfunction

  // bursts of adds then takes with random content, plus some raw noise
  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned made, burst, k;
    in_item_t    req;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        req.action       = 1'($urandom);
        req.job_id       = ID_W'($urandom);
        req.job_length   = LEN_W'($urandom);
        req.server_index = SRV_FIELD_W'($urandom);
        push_job(req);
        made++;
      end else begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst; k++) push_job(make_add(ID_W'($urandom), random_length()));
        made += burst;
        burst = $urandom_range(1, 16);
        for (k = 0; k < burst; k++) push_job(make_take(pick_take_server()));
        made += burst;
      end
    end
  endtask

  // hold off until every queued transaction has produced its result
  task automatic wait_drained();
    @(negedge clk);
    while (unsent_jobs != 0 || dispatch_outcomes_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_active_count(input logic [ACTIVE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (job_requests_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= job_requests_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: check results, then predict on accepted transactions
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        active_cfg = cfg_data;
        cfg_writes++;
      end
      if (out_valid && out_ready) begin
        if (dispatch_outcomes_q.size() == 0) begin
          flag_error($sformatf("unexpected result srv=%0d id=%h len=%h st=%0d load=%0d",
                     out_data.chosen_server, out_data.out_job_id, out_data.out_job_length,
                     out_data.status, out_data.server_load));
        end else begin
          want = dispatch_outcomes_q.pop_front();
          if (out_data.chosen_server !== want.chosen_server ||
              out_data.out_job_id !== want.out_job_id ||
              out_data.out_job_length !== want.out_job_length ||
              out_data.status !== want.status ||
              out_data.server_load !== want.server_load)
            flag_error($sformatf({"mismatch exp srv=%0d id=%h len=%h st=%0d load=%0d",
                                  " got srv=%0d id=%h len=%h st=%0d load=%0d"},
                       want.chosen_server, want.out_job_id, want.out_job_length,
                       want.status, want.server_load,
                       out_data.chosen_server, out_data.out_job_id, out_data.out_job_length,
                       out_data.status, out_data.server_load));
        end
      end
      if (in_valid && in_ready) begin
        want = dispatch_outcome(in_data);
        dispatch_outcomes_q = {dispatch_outcomes_q, want};
        unsent_jobs--;
      end
    end
  end

  // main sequence
  initial begin
    int unsigned seg;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      srv_head[i]  = '0;
      srv_count[i] = '0;
      srv_load[i]  = '0;
    end
    seg_active = '{3'd1, 3'd4, 3'd0, 3'd2, 3'd7, 3'd3};
    send_idle_pct = 14;
    recv_idle_pct = 53;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty takes on every server, extreme adds, ties, then drain each queue
    for (int i = 0; i < NUM_SERVERS; i++) push_job(make_take(SRV_FIELD_W'(i)));
    push_job(make_add(16'h0000, 8'h00));
    push_job(make_add(16'hFFFF, 8'hFF));
    push_job(make_add(16'h5555, 8'hAA));
    push_job(make_add(16'hAAAA, 8'h55));
    push_job(make_add(16'h1234, 8'h00));
    push_job(make_add(16'h00FF, 8'h01));
    push_job(make_take(2'd0));
    push_job(make_take(2'd0));
    push_job(make_take(2'd1));
    push_job(make_take(2'd2));
    push_job(make_take(2'd3));
    push_job(make_take(2'd3));
    push_job(make_take(2'd3));
    wait_drained();

    // single dispatching server, take from a server outside dispatch
    write_active_count(3'd1);
    push_job(make_add(16'h8001, 8'h80));
    push_job(make_add(16'h7FFE, 8'h7F));
    push_job(make_take(2'd3));
    push_job(make_take(2'd0));
    wait_drained();

    // random phases, each under its own active-server count; the idling pattern changes every two phases
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 53;
      end else if (seg < 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_active_count(seg_active[seg]);
      if (seg == 0) begin
        // sender holds off mid-phase until all results are back
        queue_random_traffic(SEG_ITEMS / 2);
        wait_drained();
        queue_random_traffic(SEG_ITEMS / 2);
      end else begin
        queue_random_traffic(SEG_ITEMS);
      end
      wait_drained();
    end

    $display("covered %0d adds (%0d dropped on a full queue), %0d takes, %0d on an empty queue",
             added_jobs + dropped_adds, dropped_adds, served_jobs + empty_takes, empty_takes);
    $display("over %0d active-server settings, %0d errors found", cfg_writes, fail_count);
    if (fail_count == 0 && dispatch_outcomes_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("run timed out with %0d results outstanding", dispatch_outcomes_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
